// ===== rtl/ecd_pkg.sv =====
// ----------------------------------------------------------------------------
// ecd_pkg
// Shared types, constants and tables of the epoch-to-civil-date converter.
// ----------------------------------------------------------------------------
package ecd_pkg;

    localparam int SECONDS_BITS_DEF = 40;
    localparam int OFFSET_W         = 18;
    localparam int NS_W             = 30;
    localparam int DIVISOR_W        = 18;
    localparam int SMALL_W          = 18;
    localparam int OUT_W            = 88;
    localparam int DIGIT_W          = 14;
    localparam int RECIP_W          = 32;

    localparam logic [30:0] NS_PER_SEC  = 31'd1000000000;
    localparam int          CIVIL_SHIFT = 719468;

    typedef enum logic [3:0] {
        OP_DAYS,
        OP_ERA,
        OP_Y1460,
        OP_Y36524,
        OP_Y146096,
        OP_YOE,
        OP_Y100,
        OP_MP,
        OP_WD,
        OP_HR,
        OP_MN
    } div_op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_NORM,
        ST_START,
        ST_RUN,
        ST_STORE,
        ST_FIN1,
        ST_FIN2
    } ctrl_state_t;

    typedef struct packed {
        logic    load;
        logic    ns_step;
        logic    div_start;
        logic    store;
        logic    fin1;
        logic    fin2;
        div_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic ns_fix;
        logic div_done;
        logic out_busy;
    } dp_status_t;

    function automatic logic [DIVISOR_W-1:0] divisor_of(input div_op_t op);
        logic [DIVISOR_W-1:0] d;
        case (op)
            OP_DAYS:    d = 18'd86400;
            OP_ERA:     d = 18'd146097;
            OP_Y1460:   d = 18'd1460;
            OP_Y36524:  d = 18'd36524;
            OP_Y146096: d = 18'd146096;
            OP_YOE:     d = 18'd365;
            OP_Y100:    d = 18'd100;
            OP_MP:      d = 18'd153;
            OP_WD:      d = 18'd7;
            OP_HR:      d = 18'd3600;
            OP_MN:      d = 18'd60;
            default:    d = 18'd1;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor) for each operation
    function automatic logic [RECIP_W-1:0] recip_of(input div_op_t op);
        logic [RECIP_W-1:0] m;
        case (op)
            OP_DAYS:    m = 32'd49710;
            OP_ERA:     m = 32'd29398;
            OP_Y1460:   m = 32'd2941758;
            OP_Y36524:  m = 32'd117593;
            OP_Y146096: m = 32'd29398;
            OP_YOE:     m = 32'd11767033;
            OP_Y100:    m = 32'd42949672;
            OP_MP:      m = 32'd28071681;
            OP_WD:      m = 32'd613566756;
            OP_HR:      m = 32'd1193046;
            OP_MN:      m = 32'd71582788;
            default:    m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    // first day of each month counted from March 1
    function automatic logic [8:0] march_start(input logic [3:0] mp);
        logic [8:0] s;
        case (mp)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

    function automatic logic [8:0] days_before(input logic leap, input logic [3:0] mon);
        logic [8:0] s;
        case (mon)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd59;
            4'd3:    s = 9'd90;
            4'd4:    s = 9'd120;
            4'd5:    s = 9'd151;
            4'd6:    s = 9'd181;
            4'd7:    s = 9'd212;
            4'd8:    s = 9'd243;
            4'd9:    s = 9'd273;
            4'd10:   s = 9'd304;
            4'd11:   s = 9'd334;
            default: s = 9'd0;
        endcase
        if (leap && mon >= 4'd2)
        begin
            s = s + 9'd1;
        end
        return s;
    endfunction

endpackage

// ===== rtl/ecd_div.sv =====
// ----------------------------------------------------------------------------
// ecd_div
// Unsigned divider by a table constant, one 14-bit quotient digit at a time in
// two steps: reciprocal multiply, then remainder and one correction step.
// ----------------------------------------------------------------------------
module ecd_div
    import ecd_pkg::*;
#(
    parameter int DW = SECONDS_BITS_DEF + 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 big,
    input  logic [DW-1:0]        dividend,
    input  logic [DIVISOR_W-1:0] divisor,
    input  logic [RECIP_W-1:0]   recip,
    output logic                 done,
    output logic [DW-1:0]        quo,
    output logic [DIVISOR_W-1:0] rem
);

    localparam int NB  = (DW + DIGIT_W - 1) / DIGIT_W;
    localparam int NS  = (SMALL_W + DIGIT_W - 1) / DIGIT_W;
    localparam int PW  = NB * DIGIT_W;
    localparam int VW  = DIVISOR_W + DIGIT_W;
    localparam int PRW = VW + RECIP_W;
    localparam int CW  = $clog2(NB + 1);

    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 phase_reg, phase_next;
    logic [PW-1:0]        quo_reg, quo_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] div_reg, div_next;
    logic [RECIP_W-1:0]   recip_reg, recip_next;
    logic [DIGIT_W-1:0]   qd_reg, qd_next;
    logic [VW-1:0]        v;
    logic [PRW-1:0]       prod;
    logic [VW-1:0]        back, r0, r1;
    logic                 fits;

    assign v    = {rem_reg, quo_reg[PW-1 -: DIGIT_W]};
    assign prod = PRW'(v) * PRW'(recip_reg);
    assign back = VW'(qd_reg) * VW'(div_reg);
    assign r0   = v - back;
    assign fits = r0 >= VW'(div_reg);
    assign r1   = fits ? (r0 - VW'(div_reg)) : r0;

    always_comb
    begin
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        recip_next = recip_reg;
        qd_next    = qd_reg;
        if (start)
        begin
            div_next   = divisor;
            recip_next = recip;
            rem_next   = '0;
            phase_next = 1'b0;
            if (big)
            begin
                quo_next = PW'(dividend);
                cnt_next = CW'(NB);
            end
            else
            begin
                quo_next = {(NS * DIGIT_W)'(dividend[SMALL_W-1:0]),
                            {(PW - NS * DIGIT_W){1'b0}}};
                cnt_next = CW'(NS);
            end
        end
        else if (cnt_reg != '0)
        begin
            if (!phase_reg)
            begin
                qd_next    = prod[RECIP_W+DIGIT_W-1:RECIP_W];
                phase_next = 1'b1;
            end
            else
            begin
                rem_next   = r1[DIVISOR_W-1:0];
                quo_next   = {quo_reg[PW-DIGIT_W-1:0], qd_reg + DIGIT_W'(fits)};
                cnt_next   = cnt_reg - CW'(1);
                phase_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            phase_reg <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
        recip_reg <= recip_next;
        qd_reg    <= qd_next;
    end

    assign done = (cnt_reg == '0);
    assign quo  = quo_reg[DW-1:0];
    assign rem  = rem_reg;

endmodule

// ===== rtl/ecd_dp.sv =====
// ----------------------------------------------------------------------------
// ecd_dp
// Datapath: sign and offset, nanosecond borrow, divider operands, date fields.
// ----------------------------------------------------------------------------
module ecd_dp
    import ecd_pkg::*;
#(
    parameter int SECONDS_BITS = SECONDS_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    input  logic [((1 + SECONDS_BITS + NS_W + 7) / 8) * 8 - 1:0] in_data,
    input  logic [OFFSET_W-1:0] offset,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [OUT_W-1:0]    out_data
);

    localparam int DW = SECONDS_BITS + 2;

    logic [DW-1:0]        sec_reg, sec_next, z_reg;
    logic [30:0]          ns_reg, ns_next;
    logic [16:0]          sod_reg, era_reg, year_reg;
    logic [17:0]          doe_reg;
    logic [6:0]           t1_reg;
    logic [2:0]           t2_reg;
    logic                 t3_reg;
    logic [8:0]           yoe_reg, doy_reg, y400_reg;
    logic [3:0]           mp_reg, mon_reg;
    logic [4:0]           md_reg, hour_reg;
    logic [2:0]           wday_reg;
    logic [11:0]          sodr_reg;
    logic [5:0]           min_reg, secm_reg;
    logic                 out_valid_reg;
    logic [OUT_W-1:0]     out_reg;

    logic [DW-1:0]        sec_mag, z_mag, dvd, quo, q_fix;
    logic [SMALL_W-1:0]   small_dvd;
    logic [DIVISOR_W-1:0] divisor, rem, r_fix;
    logic [RECIP_W-1:0]   recip;
    logic                 big, div_done, dvd_neg, r_nz;
    logic [DW-1:0]        mag_in;
    logic [30:0]          ns_in;
    logic                 ns_hi, ns_lo;
    logic [3:0]           mon_calc;
    logic                 adj, leap;

    assign mag_in = DW'(in_data[SECONDS_BITS:1]);
    assign ns_in  = {1'b0, in_data[SECONDS_BITS+NS_W:SECONDS_BITS+1]};
    assign ns_hi  = $signed(ns_reg) >= $signed(NS_PER_SEC);
    assign ns_lo  = ns_reg[30];

    always_comb
    begin
        sec_next = sec_reg;
        ns_next  = ns_reg;
        if (cmd.load)
        begin
            sec_next = (in_data[0] ? (-mag_in) : mag_in) + DW'($signed(offset));
            ns_next  = in_data[0] ? (-ns_in) : ns_in;
        end
        else if (cmd.ns_step)
        begin
            if (ns_hi)
            begin
                ns_next  = ns_reg - NS_PER_SEC;
                sec_next = sec_reg + DW'(1);
            end
            else
            begin
                ns_next  = ns_reg + NS_PER_SEC;
                sec_next = sec_reg - DW'(1);
            end
        end
    end

    assign sec_mag = sec_reg[DW-1] ? (-sec_reg) : sec_reg;
    assign z_mag   = z_reg[DW-1] ? (-z_reg) : z_reg;
    assign divisor = divisor_of(cmd.op);
    assign recip   = recip_of(cmd.op);

    always_comb
    begin
        big       = 1'b0;
        small_dvd = doe_reg;
        case (cmd.op)
            OP_DAYS:    big = 1'b1;
            OP_ERA:     big = 1'b1;
            OP_Y1460:   small_dvd = doe_reg;
            OP_Y36524:  small_dvd = doe_reg;
            OP_Y146096: small_dvd = doe_reg;
            OP_YOE:     small_dvd = doe_reg - SMALL_W'(t1_reg) + SMALL_W'(t2_reg)
                                    - SMALL_W'(t3_reg);
            OP_Y100:    small_dvd = SMALL_W'(yoe_reg);
            OP_MP:      small_dvd = SMALL_W'(doy_reg) * SMALL_W'(5) + SMALL_W'(2);
            OP_WD:      small_dvd = doe_reg + SMALL_W'(3);
            OP_HR:      small_dvd = SMALL_W'(sod_reg);
            OP_MN:      small_dvd = SMALL_W'(sodr_reg);
            default:    small_dvd = doe_reg;
        endcase
        if (cmd.op == OP_DAYS)
        begin
            dvd = sec_mag;
        end
        else if (cmd.op == OP_ERA)
        begin
            dvd = z_mag;
        end
        else
        begin
            dvd = DW'(small_dvd);
        end
    end

    ecd_div #(.DW(DW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .big      (big),
        .dividend (dvd),
        .divisor  (divisor),
        .recip    (recip),
        .done     (div_done),
        .quo      (quo),
        .rem      (rem)
    );

    assign dvd_neg = (cmd.op == OP_DAYS) ? sec_reg[DW-1] : z_reg[DW-1];
    assign r_nz    = (rem != '0);
    assign q_fix   = dvd_neg ? (r_nz ? ~quo : -quo) : quo;
    assign r_fix   = dvd_neg ? (r_nz ? divisor - rem : '0) : rem;

    assign mon_calc = (mp_reg < 4'd10) ? mp_reg + 4'd2 : mp_reg - 4'd10;
    assign adj      = (mp_reg >= 4'd10);
    assign leap     = (y400_reg[1:0] == 2'd0) && (y400_reg != 9'd100)
                      && (y400_reg != 9'd200) && (y400_reg != 9'd300);

    always_ff @(posedge clk)
    begin
        sec_reg <= sec_next;
        ns_reg  <= ns_next;
        if (cmd.store)
        begin
            case (cmd.op)
                OP_DAYS:
                begin
                    z_reg   <= q_fix + DW'(CIVIL_SHIFT);
                    sod_reg <= r_fix[16:0];
                end
                OP_ERA:
                begin
                    era_reg <= q_fix[16:0];
                    doe_reg <= r_fix;
                end
                OP_Y1460:   t1_reg  <= quo[6:0];
                OP_Y36524:  t2_reg  <= quo[2:0];
                OP_Y146096: t3_reg  <= quo[0];
                OP_YOE:     yoe_reg <= quo[8:0];
                OP_Y100:
                    doy_reg <= 9'(doe_reg - (SMALL_W'(yoe_reg) * SMALL_W'(365)
                               + SMALL_W'(yoe_reg[8:2]) - SMALL_W'(quo[2:0])));
                OP_MP:      mp_reg  <= quo[3:0];
                OP_WD:      wday_reg <= rem[2:0];
                OP_HR:
                begin
                    hour_reg <= quo[4:0];
                    sodr_reg <= rem[11:0];
                end
                OP_MN:
                begin
                    min_reg  <= quo[5:0];
                    secm_reg <= rem[5:0];
                end
                default:
                begin
                    mp_reg <= mp_reg;
                end
            endcase
        end
        if (cmd.fin1)
        begin
            mon_reg  <= mon_calc;
            md_reg   <= 5'(doy_reg - march_start(mp_reg));
            y400_reg <= yoe_reg + 9'(adj);
            year_reg <= 17'(yoe_reg) + 17'(adj) + era_reg * 17'd400;
        end
        if (cmd.fin2)
        begin
            out_reg <= {3'b000, ns_reg[NS_W-1:0], secm_reg, min_reg, hour_reg, wday_reg,
                        md_reg, mon_reg, days_before(leap, mon_reg) + 9'(md_reg),
                        year_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.fin2)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.ns_fix   = ns_hi || ns_lo;
    assign status.div_done = div_done;
    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_reg;

endmodule

// ===== rtl/ecd_ctrl.sv =====
// ----------------------------------------------------------------------------
// ecd_ctrl
// Sequencer: accepts a beat, steps the divider through its operations.
// ----------------------------------------------------------------------------
module ecd_ctrl
    import ecd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg, state_next;
    div_op_t     op_reg, op_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg    <= OP_DAYS;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.op        = op_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    op_next    = OP_DAYS;
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (status.ns_fix)
                begin
                    cmd.ns_step = 1'b1;
                end
                else
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_RUN;
            end
            ST_RUN:
            begin
                if (status.div_done)
                begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE:
            begin
                cmd.store = 1'b1;
                if (op_reg == OP_MN)
                begin
                    state_next = ST_FIN1;
                end
                else
                begin
                    op_next    = div_op_t'(op_reg + 4'd1);
                    state_next = ST_START;
                end
            end
            ST_FIN1:
            begin
                cmd.fin1   = 1'b1;
                state_next = ST_FIN2;
            end
            ST_FIN2:
            begin
                if (!status.out_busy)
                begin
                    cmd.fin2   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/epoch_seconds_to_civil_date_unit.sv =====
// ----------------------------------------------------------------------------
// epoch_seconds_to_civil_date_unit
// Converts a signed epoch time to a Gregorian date and time of day.
// ----------------------------------------------------------------------------
// One input beat on s_axis carries sign, seconds and nanoseconds; one result
// beat on m_axis carries year, day of year, month, day, weekday and time.
// cfg_wr_en/cfg_wr_data write the UTC offset; write it only while idle.
// From acceptance to m_tvalid an item goes through zero to two nanosecond
// borrow steps and eleven divisions on the shared constant divider, which
// yields one 14-bit quotient digit at a time: ceil((SECONDS_BITS + 2) / 14)
// digits for the first two divisions and two digits for each of the others.
// s_tready is high only while no item is in flight. A finished result waits
// in the output register; the next item is accepted meanwhile, and its
// result is held back until m_tready frees that register.
// Reset clears the offset to zero, empties the output and returns to idle.
// ----------------------------------------------------------------------------
module epoch_seconds_to_civil_date_unit
    import ecd_pkg::*;
#(
    parameter int SECONDS_BITS = SECONDS_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [OFFSET_W-1:0] cfg_wr_data,   // utc_offset_seconds
    input  logic                s_tvalid,
    output logic                s_tready,
    // is_negative, seconds_magnitude, nanoseconds_magnitude
    input  logic [((1 + SECONDS_BITS + NS_W + 7) / 8) * 8 - 1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // year, day_of_year, month_index, day_of_month, weekday, hour_of_day,
    // minute_of_hour, second_of_minute, nanosecond_of_second
    output logic [OUT_W-1:0]    m_tdata
);

    logic [OFFSET_W-1:0] offset_reg;
    dp_cmd_t             cmd;
    dp_status_t          status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            offset_reg <= cfg_wr_data;
        end
    end

    ecd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ecd_dp #(.SECONDS_BITS(SECONDS_BITS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_tdata),
        .offset    (offset_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item accepted while busy");

    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[29:26] <= 4'd11) && (m_tdata[34:30] <= 5'd30))
        else $error("month or day out of range");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[42:38] <= 5'd23) && (m_tdata[84:55] < 30'd1000000000))
        else $error("hour or nanosecond out of range");

endmodule

// ===== tb/civil_date_checker.sv =====
// ----------------------------------------------------------------------------
// civil_date_checker
// Watches the input, result and offset channels of the epoch-to-civil-date
// converter, predicts the civil date of every accepted input beat and
// compares each result beat with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module civil_date_checker
    import ecd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [OFFSET_W-1:0] cfg_wr_data,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [71:0]         s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [OUT_W-1:0]    m_tdata,
    output int                  fail_count,
    output int                  pending_dates,
    output int                  dates_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [29:0] nsec;
        logic [5:0]  sec;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [2:0]  wday;
        logic [4:0]  mday;
        logic [3:0]  mon;
        logic [8:0]  yday;
        logic [16:0] year;
    } civil_t;

    civil_t             date_q[$];
    logic [OFFSET_W-1:0] offset_reg;

    function automatic longint fdiv(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && ((a < 0) != (b < 0)))
        begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic longint month_start(input longint mon, input bit leap);
        longint s;
        case (mon)
            0:       s = 0;
            1:       s = 31;
            2:       s = 59;
            3:       s = 90;
            4:       s = 120;
            5:       s = 151;
            6:       s = 181;
            7:       s = 212;
            8:       s = 243;
            9:       s = 273;
            10:      s = 304;
            default: s = 334;
        endcase
        if (leap && mon >= 2)
        begin
            s = s + 1;
        end
        return s;
    endfunction

    function automatic civil_t civil_of(input logic [71:0] beat,
                                        input logic [OFFSET_W-1:0] off);
        civil_t r;
        longint secs, ns, carry, days, sod, z, era, doe, yoe, doy, mp, md, mon, yr;
        bit leap;
        secs = longint'(beat[40:1]);
        ns   = longint'(beat[70:41]);
        if (beat[0])
        begin
            secs = -secs;
            ns   = -ns;
        end
        secs  = secs + longint'($signed(off));
        carry = fdiv(ns, 1000000000);
        ns    = ns - carry * 1000000000;
        secs  = secs + carry;
        days  = fdiv(secs, 86400);
        sod   = secs - days * 86400;
        z     = days + 719468;
        era   = fdiv(z, 146097);
        doe   = z - era * 146097;
        yoe   = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
        yr    = yoe + era * 400;
        doy   = doe - (365 * yoe + yoe / 4 - yoe / 100);
        mp    = (5 * doy + 2) / 153;
        md    = doy - (153 * mp + 2) / 5;
        mon   = (mp < 10) ? mp + 2 : mp - 10;
        if (mon <= 1)
        begin
            yr = yr + 1;
        end
        leap     = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
        r.year   = yr[16:0];
        r.yday   = 9'(month_start(mon, leap) + md);
        r.mon    = mon[3:0];
        r.mday   = md[4:0];
        r.wday   = 3'(days - fdiv(days + 4, 7) * 7 + 4);
        r.hour   = 5'(sod / 3600);
        r.minute = 6'((sod % 3600) / 60);
        r.sec    = 6'(sod % 60);
        r.nsec   = ns[29:0];
        return r;
    endfunction

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        civil_t want, got;
        if (!rst_n)
        begin
            offset_reg    <= '0;
            date_q.delete();
            fail_count    = 0;
            dates_checked = 0;
            pending_dates = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                offset_reg <= cfg_wr_data;
            end
            if (s_tvalid && s_tready)
            begin
                date_q.push_back(civil_of(s_tdata, offset_reg));
            end
            if (m_tvalid && m_tready)
            begin
                got = civil_t'(m_tdata[84:0]);
                if (date_q.size() == 0)
                begin
                    $display("%0t: unexpected result beat %h", $time, m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = date_q.pop_front();
                    check_field("year", $signed(want.year), $signed(got.year));
                    check_field("day_of_year", want.yday, got.yday);
                    check_field("month_index", want.mon, got.mon);
                    check_field("day_of_month", want.mday, got.mday);
                    check_field("weekday", want.wday, got.wday);
                    check_field("hour_of_day", want.hour, got.hour);
                    check_field("minute_of_hour", want.minute, got.minute);
                    check_field("second_of_minute", want.sec, got.sec);
                    check_field("nanosecond_of_second", want.nsec, got.nsec);
                    dates_checked++;
                end
            end
            pending_dates = date_q.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives epoch times through the civil-date converter under several UTC
// offsets, with random gaps on the input and random stalls on the result.
// ----------------------------------------------------------------------------
module tb;
    import ecd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [OFFSET_W-1:0] cfg_wr_data = '0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [71:0]         s_tdata = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [OUT_W-1:0]    m_tdata;
    int                  fail_count, pending_dates, dates_checked;
    int                  beats_sent = 0;
    int                  stall_left = 0;

    always #5 clk = ~clk;

    epoch_seconds_to_civil_date_unit DUT (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    civil_date_checker checker_i (
        .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .pending_dates(pending_dates),
        .dates_checked(dates_checked)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 400);
    endfunction

    // result-side stalls
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            stall_left <= gap_len();
            m_tready   <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_time(input bit neg, input logic [39:0] secs, input logic [29:0] ns);
        int gap;
        s_tdata  <= {1'b0, ns, secs, neg};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        beats_sent++;
        gap = ($urandom_range(0, 9) < 3) ? 0 : gap_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // write the offset once the converter has drained
    task automatic set_offset(input logic [OFFSET_W-1:0] off);
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_dates != 0);
        repeat (300) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= off;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic send_random();
        logic [39:0] secs;
        logic [29:0] ns;
        int pick;
        pick = $urandom_range(0, 9);
        secs = 40'({$urandom(), $urandom()});
        if (pick < 3)
        begin
            secs = 40'($urandom_range(0, 2000000000)) * 2;
        end
        else if (pick < 5)
        begin
            secs = 40'($urandom_range(0, 200000)) * 86400 + 40'($urandom_range(0, 2)) - 1;
        end
        else if (pick < 6)
        begin
            secs = 40'($urandom_range(0, 100));
        end
        ns = ($urandom_range(0, 9) == 0) ? 30'($urandom()) : 30'($urandom_range(0, 999999999));
        send_time(1'($urandom_range(0, 1)), secs, ns);
    endtask

    initial
    begin
        logic [OFFSET_W-1:0] offsets [6];
        offsets = '{18'd86399, -18'sd86399, 18'h1FFFF, 18'h20000, 18'd3600, 18'd0};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_time(1'b0, 40'd0, 30'd0);
        send_time(1'b1, 40'd0, 30'd0);
        send_time(1'b1, 40'd0, 30'd1);
        send_time(1'b0, 40'd0, 30'd999999999);
        send_time(1'b0, 40'd0, 30'd1000000000);
        send_time(1'b0, 40'hFF_FFFF_FFFF, 30'h3FFF_FFFF);
        send_time(1'b1, 40'hFF_FFFF_FFFF, 30'h3FFF_FFFF);
        send_time(1'b1, 40'd1, 30'd0);
        send_time(1'b0, 40'd86399, 30'd999999999);
        send_time(1'b0, 40'd86400, 30'd0);
        send_time(1'b1, 40'd86400, 30'd1);
        send_time(1'b0, 40'd951782400, 30'd5);
        send_time(1'b0, 40'd951868800, 30'd5);
        send_time(1'b0, 40'd4107542400, 30'd0);
        send_time(1'b1, 40'd62167219200, 30'd0);
        send_time(1'b1, 40'd62167219201, 30'd0);
        send_time(1'b0, 40'd978307199, 30'd500000000);

        foreach (offsets[i])
        begin
            set_offset(offsets[i]);
            send_time(1'b0, 40'd0, 30'd0);
            send_time(1'b1, 40'hFF_FFFF_FFFF, 30'h3FFF_FFFF);
            repeat (150) send_random();
            set_offset(18'($urandom()));
            repeat (70) send_random();
        end

        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_dates != 0);
        repeat (400) @(posedge clk);
        $display("Converted %0d epoch times under 13 offset settings, %0d results checked.",
                 beats_sent, dates_checked);
        if (fail_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    initial
    begin
        #40ms;
        $display("Timeout with %0d results outstanding.", pending_dates);
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== epoch_seconds_to_civil_date_unit.f =====
rtl/ecd_pkg.sv
rtl/ecd_div.sv
rtl/ecd_dp.sv
rtl/ecd_ctrl.sv
rtl/epoch_seconds_to_civil_date_unit.sv
tb/civil_date_checker.sv
tb/tb.sv
